// ----- rtl/dcr_pkg.sv -----
// Shared types and constants for the block DC offset remover.
package dcr_pkg;

  localparam int SAMPLE_W = 16;

  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic signed [SAMPLE_W-1:0] ac_t;

  localparam ac_t AC_MAX = ac_t'(17'sd32767);
  localparam ac_t AC_MIN = ac_t'(-17'sd32768);

  // One sample with its place in the block.
  typedef struct packed {
    sample_t raw;
    logic    first;
    logic    last;
  } item_t;

endpackage

// ----- rtl/dcr_history.sv -----
// Block position tracking, block sum history and running total of the history.
module dcr_history #(
  parameter int BLOCK_SAMPLES  = 128,
  parameter int HISTORY_BLOCKS = 16,
  parameter int POS_W          = 7,
  parameter int SLOT_W         = 4,
  parameter int ACC_W          = 23,
  parameter int TOT_W          = 27
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc_i,
  input  dcr_pkg::sample_t    raw_i,
  output dcr_pkg::item_t      item_o,
  output logic [TOT_W-1:0]    total_o
);
  import dcr_pkg::*;

  logic [POS_W-1:0]  pos_r;
  logic [SLOT_W-1:0] slot_r;
  logic [ACC_W-1:0]  acc_r;
  logic [TOT_W-1:0]  total_r;
  logic [ACC_W-1:0]  sums_mem [HISTORY_BLOCKS];
  logic [HISTORY_BLOCKS-1:0] vld_r;
  logic [ACC_W-1:0]  old_r;

  logic              first;
  logic              last;
  logic [ACC_W-1:0]  acc_sum;
  logic [SLOT_W-1:0] slot_nxt;
  logic [TOT_W-1:0]  total_nxt;

  assign first    = (pos_r == '0);
  assign last     = (pos_r == POS_W'(BLOCK_SAMPLES - 1));
  assign acc_sum  = acc_r + ACC_W'(raw_i);
  assign slot_nxt = (slot_r == SLOT_W'(HISTORY_BLOCKS - 1)) ? '0 : slot_r + 1'b1;
  assign total_nxt = total_r - TOT_W'(old_r) + TOT_W'(acc_sum);

  assign item_o  = '{raw: raw_i, first: first, last: last};
  assign total_o = total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      slot_r  <= '0;
      acc_r   <= '0;
      total_r <= '0;
      vld_r   <= '0;
    end else if (acc_i) begin
      if (last) begin
        pos_r         <= '0;
        slot_r        <= slot_nxt;
        acc_r         <= '0;
        total_r       <= total_nxt;
        vld_r[slot_r] <= 1'b1;
      end else begin
        pos_r <= pos_r + 1'b1;
        acc_r <= acc_sum;
      end
    end
  end

  // History store: written on block end, oldest slot read ahead of its use
  always_ff @(posedge clk) begin
    if (acc_i && last) begin
      sums_mem[slot_r] <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    old_r <= vld_r[slot_r] ? sums_mem[slot_r] : '0;
  end

endmodule

// ----- rtl/dcr_level.sv -----
// DC level: running total divided by the history span, by reciprocal multiply.
module dcr_level #(
  parameter int TOT_W = 27,
  parameter int DIV_D = 2048
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [TOT_W-1:0] total_i,
  output dcr_pkg::sample_t dc_o
);
  import dcr_pkg::*;

  localparam int DIV_L = $clog2(DIV_D);
  localparam int PW    = 2 * TOT_W + 1;
  localparam logic [63:0] RECIP =
    ((64'd1 << (TOT_W + DIV_L)) + 64'(DIV_D) - 64'd1) / 64'(DIV_D);

  logic [PW-1:0] prod_nxt;
  logic [PW-1:0] prod_r;

  // Exact floor division for any total below 2**TOT_W
  assign prod_nxt = PW'(total_i) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
    end else begin
      prod_r <= prod_nxt;
    end
  end

  assign dc_o = prod_r[TOT_W + DIV_L +: SAMPLE_W];

endmodule

// ----- rtl/dcr_pipe.sv -----
// Input and result registers with DC subtraction and saturation.
module dcr_pipe (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc_i,
  input  dcr_pkg::item_t   item_i,
  input  dcr_pkg::sample_t dc_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dcr_pkg::ac_t     ac_o,
  output logic             block_end_o
);
  import dcr_pkg::*;

  logic        s_valid_r;
  item_t       s_item_r;
  sample_t     dc_r;
  logic        o_valid_r;
  ac_t         ac_r;
  logic        end_r;

  logic        o_free;
  logic        s_move;
  sample_t     dc_use;
  logic signed [SAMPLE_W:0] diff;
  ac_t         ac_nxt;

  assign o_free     = !o_valid_r || !out_stall_i;
  assign s_move     = s_valid_r && o_free;
  assign in_stall_o = (s_valid_r && !o_free) || !rst_n;

  // Latch a fresh level on the first sample of each block
  assign dc_use = s_item_r.first ? dc_i : dc_r;
  assign diff   = $signed({1'b0, s_item_r.raw}) - $signed({1'b0, dc_use});

  always_comb begin
    if (diff > $signed((SAMPLE_W+1)'(AC_MAX))) begin
      ac_nxt = AC_MAX;
    end else if (diff < $signed((SAMPLE_W+1)'(-(SAMPLE_W+1)'(32768)))) begin
      ac_nxt = AC_MIN;
    end else begin
      ac_nxt = ac_t'(diff[SAMPLE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      if (acc_i) begin
        s_valid_r <= 1'b1;
      end else if (s_move) begin
        s_valid_r <= 1'b0;
      end
      if (o_free) begin
        o_valid_r <= s_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc_i) begin
      s_item_r <= item_i;
    end
    if (s_move) begin
      ac_r  <= ac_nxt;
      end_r <= s_item_r.last;
      if (s_item_r.first) begin
        dc_r <= dc_i;
      end
    end
  end

  assign out_valid_o = o_valid_r;
  assign ac_o        = ac_r;
  assign block_end_o = end_r;

endmodule

// ----- rtl/block_dc_offset_remover_core.sv -----
// Block DC offset remover: top level.
//
// Takes unsigned ADC samples on the in_ channel and returns each sample with
// the DC level removed, saturated to signed 16 bits, on the out_ channel,
// together with a flag on the last sample of every block of BLOCK_SAMPLES.
// The DC level for a block is the sum of the last HISTORY_BLOCKS block sums
// divided by HISTORY_BLOCKS * BLOCK_SAMPLES, fixed at the block's first sample.
// An accepted item moves from the input register to the result register as
// soon as that is free; one item per cycle is sustained while out_stall is
// low, set by the single input register. The divide is a constant reciprocal
// multiply, registered once, and finishes before the next block can start.
// Reset (synchronous, rst_n low) clears the history, so the level starts at
// zero and builds up over the first HISTORY_BLOCKS blocks; no item is taken
// during reset. When out_stall is held the result waits in its register and
// an item is still taken if the input register is empty, then in_stall rises.
module block_dc_offset_remover_core #(
  parameter int BLOCK_SAMPLES  = 128,
  parameter int HISTORY_BLOCKS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  dcr_pkg::sample_t in_raw_sample,
  output logic             out_valid,
  input  logic             out_stall,
  output dcr_pkg::ac_t     out_ac_sample,
  output logic             out_block_end
);
  import dcr_pkg::*;

  localparam int POS_W  = $clog2(BLOCK_SAMPLES);
  localparam int SLOT_W = $clog2(HISTORY_BLOCKS);
  localparam int ACC_W  = SAMPLE_W + POS_W;
  localparam int TOT_W  = ACC_W + SLOT_W;
  localparam int DIV_D  = HISTORY_BLOCKS * BLOCK_SAMPLES;

  logic             in_acc;
  item_t            item;
  logic [TOT_W-1:0] total;
  sample_t          dc;

  assign in_acc = in_valid && !in_stall;

  dcr_history #(
    .BLOCK_SAMPLES  (BLOCK_SAMPLES),
    .HISTORY_BLOCKS (HISTORY_BLOCKS),
    .POS_W          (POS_W),
    .SLOT_W         (SLOT_W),
    .ACC_W          (ACC_W),
    .TOT_W          (TOT_W)
  ) u_history (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc_i   (in_acc),
    .raw_i   (in_raw_sample),
    .item_o  (item),
    .total_o (total)
  );

  dcr_level #(
    .TOT_W (TOT_W),
    .DIV_D (DIV_D)
  ) u_level (
    .clk     (clk),
    .rst_n   (rst_n),
    .total_i (total),
    .dc_o    (dc)
  );

  dcr_pipe u_pipe (
    .clk         (clk),
    .rst_n       (rst_n),
    .acc_i       (in_acc),
    .item_i      (item),
    .dc_i        (dc),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .ac_o        (out_ac_sample),
    .block_end_o (out_block_end)
  );

endmodule

// ----- tb/sv/tb_block_dc_offset_remover_core.sv -----
// Testbench for block_dc_offset_remover_core: random and directed ADC items against a predictor.
module tb_block_dc_offset_remover_core;
  import dcr_pkg::*;

  localparam int BLK_LEN   = 128;
  localparam int HIST_LEN  = 16;
  localparam int LEVEL_DIV = BLK_LEN * HIST_LEN;
  localparam int LONG_HOLD = 80;

  typedef struct packed {
    ac_t  ac;
    logic last;
  } ac_result_t;

  typedef enum {PROF_FULL, PROF_LOW, PROF_HIGH, PROF_RAILS, PROF_MID} level_profile_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t in_raw_sample = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  ac_t     out_ac_sample;
  logic    out_block_end;

  // predictor state
  logic [22:0] hist_sums [HIST_LEN];
  logic [26:0] hist_total;
  logic [22:0] blk_acc;
  logic [3:0]  hist_slot;
  logic [6:0]  blk_pos;
  sample_t     dc_level;

  ac_result_t ac_due [$];
  int         mismatches = 0;
  logic       steady = 1'b0;
  logic       hold_req = 1'b0;
  logic       hold_seen = 1'b0;
  int         hold_left = 0;

  block_dc_offset_remover_core #(
    .BLOCK_SAMPLES (BLK_LEN),
    .HISTORY_BLOCKS(HIST_LEN)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_raw_sample(in_raw_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_ac_sample(out_ac_sample),
    .out_block_end(out_block_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("FAIL block_dc_offset_remover_core");
    $finish;
  end

  // Subtract the block's DC level, clamp, and roll the history on the last item.
  function automatic void remove_dc(sample_t raw);
    int         diff;
    ac_result_t r;
    if (blk_pos == 0) begin
      dc_level = sample_t'(hist_total / LEVEL_DIV);
      blk_acc  = '0;
    end
    blk_acc = blk_acc + 23'(raw);
    diff = int'(raw) - int'(dc_level);
    if (diff > int'(AC_MAX)) r.ac = AC_MAX;
    else if (diff < int'(AC_MIN)) r.ac = AC_MIN;
    else r.ac = ac_t'(diff);
    r.last = (blk_pos == 7'(BLK_LEN - 1));
    ac_due.push_back(r);
    if (r.last) begin
      hist_total = hist_total - 27'(hist_sums[hist_slot]) + 27'(blk_acc);
      hist_sums[hist_slot] = blk_acc;
      hist_slot = hist_slot + 4'd1;
      blk_pos = '0;
    end else begin
      blk_pos = blk_pos + 7'd1;
    end
  endfunction

  function automatic sample_t pick_sample(level_profile_t prof);
    unique case (prof)
      PROF_LOW:   return ($urandom_range(15) == 0) ? sample_t'(0) : sample_t'($urandom_range(4095));
      PROF_HIGH:  return sample_t'($urandom_range(65535, 60000));
      PROF_RAILS: return $urandom_range(1) ? sample_t'(65535) : sample_t'(0);
      PROF_MID:   return sample_t'($urandom_range(33768, 31768));
      default:    return sample_t'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_sample(input sample_t v);
    while (!steady && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_raw_sample <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    remove_dc(v);
  endtask

  // Receiver: check each accepted result, then decide the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (ac_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: ac_sample %0d block_end %0b", out_ac_sample, out_block_end);
        mismatches++;
      end else begin
        if (out_ac_sample !== ac_due[0].ac || out_block_end !== ac_due[0].last) begin
          if (mismatches < 10)
            $display("mismatch: ac_sample exp %0d got %0d, block_end exp %0b got %0b",
                     ac_due[0].ac, out_ac_sample, ac_due[0].last, out_block_end);
          mismatches++;
        end
        void'(ac_due.pop_front());
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 13);
    end
  end

  // Rails, single bits and the saturation edge while the level is still zero.
  task automatic test_directed();
    sample_t vals [$];
    vals = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001, 16'h7FFE, 16'hAAAA, 16'h5555,
             16'h0001, 16'hFFFE, 16'h0000, 16'hFFFF};
    foreach (vals[i]) send_sample(vals[i]);
    for (int b = 0; b < 12; b++) begin
      send_sample(sample_t'(1) << b % 16);
      if (b < 4) send_sample(~(sample_t'(1) << (b + 12)));
    end
  endtask

  // Drive the level up past mid-scale so that low items clamp at the bottom.
  task automatic test_rising_level();
    steady <= 1'b1;
    for (int i = 0; i < 11 * BLK_LEN; i++) begin
      if (i == 3 * BLK_LEN) steady <= 1'b0;
      send_sample(pick_sample(($urandom_range(7) == 0) ? PROF_LOW : PROF_HIGH));
    end
  endtask

  // Hold the output off for a long stretch while items keep coming.
  task automatic test_backpressure();
    steady   <= 1'b1;
    hold_req <= ~hold_req;
    for (int i = 0; i < 48; i++) send_sample(pick_sample(PROF_FULL));
    steady <= 1'b0;
  endtask

  // A fresh level profile at every block start.
  task automatic test_mixed_blocks();
    level_profile_t prof;
    prof = PROF_FULL;
    for (int i = 0; i < 400; i++) begin
      if (blk_pos == 0) prof = level_profile_t'($urandom_range(4));
      send_sample(pick_sample(prof));
    end
  endtask

  initial begin
    for (int i = 0; i < HIST_LEN; i++) hist_sums[i] = '0;
    hist_total = '0;
    blk_acc    = '0;
    hist_slot  = '0;
    blk_pos    = '0;
    dc_level   = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_rising_level();
    test_backpressure();
    test_mixed_blocks();
    in_valid <= 1'b0;
    while (ac_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS block_dc_offset_remover_core");
    end else begin
      $display("FAIL block_dc_offset_remover_core");
    end
    $finish;
  end

endmodule
